>>> hw/rtl/cpl_pkg.sv
// Package for the C punctuator lexer: payload structs, token codes, character
// constants and the classification functions used by the front end.
// No dependencies.
package cpl_pkg;

    localparam int COUNTER_WIDTH = 24;
    localparam int FIELD_WIDTH   = 24;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);
    localparam logic [QAW:0] QCOUNT_FULL = QDEPTH[QAW:0];

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";

    typedef enum logic [5:0] {
        K_LBRACK, K_RBRACK, K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE,
        K_ELLIPSIS, K_DOT, K_ARROW, K_DEC, K_SUB_EQ, K_SUB,
        K_INC, K_ADD_EQ, K_ADD, K_LAND, K_AND_EQ, K_AND,
        K_MUL_EQ, K_MUL, K_TILDE, K_NE, K_NOT, K_DIV_EQ,
        K_DIV, K_MOD_EQ, K_MOD, K_SHL_EQ, K_SHL, K_LE,
        K_LT, K_SHR_EQ, K_SHR, K_GE, K_GT, K_EQEQ,
        K_ASSIGN, K_XOR_EQ, K_XOR, K_LOR, K_OR_EQ, K_OR,
        K_QUEST, K_COLON, K_SEMI, K_COMMA
    } t_kind;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic                   is_error;
        logic [FIELD_WIDTH-1:0] line_number;
        logic [FIELD_WIDTH-1:0] byte_offset;
        logic                   last_of_run;
    } t_out;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_lookup;

    typedef struct packed {
        t_kind kind;
        logic  err;
    } t_res;

    // All results of one source byte; they share one line and one offset.
    typedef struct packed {
        logic [1:0]             cnt;
        logic [FIELD_WIDTH-1:0] line;
        logic [FIELD_WIDTH-1:0] off;
        t_res [2:0]             res;
    } t_bundle;

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [COUNTER_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_WIDTH-1:0];
    endfunction

    function automatic t_lookup lone_kind(input logic [7:0] c);
        t_lookup r;
        r.hit = 1'b1;
        case (c)
            "[":     r.kind = K_LBRACK;
            "]":     r.kind = K_RBRACK;
            "(":     r.kind = K_LPAREN;
            ")":     r.kind = K_RPAREN;
            "{":     r.kind = K_LBRACE;
            "}":     r.kind = K_RBRACE;
            "~":     r.kind = K_TILDE;
            "?":     r.kind = K_QUEST;
            ":":     r.kind = K_COLON;
            ";":     r.kind = K_SEMI;
            ",":     r.kind = K_COMMA;
            default: begin
                r.hit  = 1'b0;
                r.kind = K_LBRACK;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup short_kind(input logic [7:0] c);
        t_lookup r;
        r.hit = 1'b1;
        case (c)
            ".":     r.kind = K_DOT;
            "-":     r.kind = K_SUB;
            "+":     r.kind = K_ADD;
            "&":     r.kind = K_AND;
            "*":     r.kind = K_MUL;
            "!":     r.kind = K_NOT;
            "/":     r.kind = K_DIV;
            "%":     r.kind = K_MOD;
            "<":     r.kind = K_LT;
            ">":     r.kind = K_GT;
            "=":     r.kind = K_ASSIGN;
            "^":     r.kind = K_XOR;
            "|":     r.kind = K_OR;
            default: begin
                r.hit  = 1'b0;
                r.kind = K_LBRACK;
            end
        endcase
        return r;
    endfunction

    function automatic t_lookup pair_kind(input logic [7:0] a, input logic [7:0] c);
        t_lookup r;
        r.hit  = 1'b1;
        r.kind = K_LBRACK;
        case (a)
            "-": begin
                if (c == ">") r.kind = K_ARROW;
                else if (c == "-") r.kind = K_DEC;
                else if (c == CH_EQ) r.kind = K_SUB_EQ;
                else r.hit = 1'b0;
            end
            "+": begin
                if (c == "+") r.kind = K_INC;
                else if (c == CH_EQ) r.kind = K_ADD_EQ;
                else r.hit = 1'b0;
            end
            "&": begin
                if (c == "&") r.kind = K_LAND;
                else if (c == CH_EQ) r.kind = K_AND_EQ;
                else r.hit = 1'b0;
            end
            "|": begin
                if (c == "|") r.kind = K_LOR;
                else if (c == CH_EQ) r.kind = K_OR_EQ;
                else r.hit = 1'b0;
            end
            "*": begin r.kind = K_MUL_EQ; r.hit = (c == CH_EQ); end
            "!": begin r.kind = K_NE;     r.hit = (c == CH_EQ); end
            "/": begin r.kind = K_DIV_EQ; r.hit = (c == CH_EQ); end
            "%": begin r.kind = K_MOD_EQ; r.hit = (c == CH_EQ); end
            "<": begin r.kind = K_LE;     r.hit = (c == CH_EQ); end
            ">": begin r.kind = K_GE;     r.hit = (c == CH_EQ); end
            "=": begin r.kind = K_EQEQ;   r.hit = (c == CH_EQ); end
            "^": begin r.kind = K_XOR_EQ; r.hit = (c == CH_EQ); end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cpl_front.sv
// Front end of the C punctuator lexer: takes one byte per transfer, keeps the
// lookahead, comment flag and counters, and pushes a result bundle for each byte that yields results.
// Depends on cpl_pkg.
module cpl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  cpl_pkg::t_in    i_in,
    output logic            o_q_push,
    output cpl_pkg::t_bundle o_bundle
);
    import cpl_pkg::*;

    logic [1:0]               r_cnt, n_cnt;
    logic [7:0]               r_p0, n_p0;
    logic                     r_com, n_com;
    logic [COUNTER_WIDTH-1:0] r_line, n_line;
    logic [COUNTER_WIDTH-1:0] r_off, n_off;
    t_bundle                  bnd;

    function automatic t_bundle add_res(input t_bundle b, input t_kind k, input logic e);
        t_bundle r;
        r = b;
        case (b.cnt)
            2'd0: begin r.res[0].kind = k; r.res[0].err = e; end
            2'd1: begin r.res[1].kind = k; r.res[1].err = e; end
            2'd2: begin r.res[2].kind = k; r.res[2].err = e; end
            default: ;
        endcase
        if (b.cnt != 2'd3) begin
            r.cnt = b.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_bundle add_held(input t_bundle b, input logic [7:0] p);
        t_bundle r;
        r = b;
        if (p == CH_DOT) begin
            r = add_res(r, K_DOT, 1'b0);
            r = add_res(r, K_DOT, 1'b0);
        end else if (p == CH_LT) begin
            r = add_res(r, K_SHL, 1'b0);
        end else begin
            r = add_res(r, K_SHR, 1'b0);
        end
        return r;
    endfunction

    always_comb begin
        logic    cont;
        logic    line_inc;
        logic [7:0] c;
        t_lookup pk;
        t_lookup sk;
        t_lookup lk;

        c        = i_in.char_byte;
        cont     = 1'b1;
        line_inc = 1'b0;
        n_cnt    = r_cnt;
        n_p0     = r_p0;
        n_com    = r_com;
        pk       = pair_kind(r_p0, c);
        sk       = short_kind(c);
        lk       = lone_kind(c);
        bnd      = '0;
        bnd.line = to_field(r_line);

        if (r_com) begin
            cont = 1'b0;
            if (c == CH_NL) begin
                n_com    = 1'b0;
                line_inc = 1'b1;
            end
        end else if (r_cnt == 2'd2) begin
            n_cnt = 2'd0;
            if (r_p0 == CH_DOT && c == CH_DOT) begin
                bnd  = add_res(bnd, K_ELLIPSIS, 1'b0);
                cont = 1'b0;
            end else if (r_p0 == CH_LT && c == CH_EQ) begin
                bnd  = add_res(bnd, K_SHL_EQ, 1'b0);
                cont = 1'b0;
            end else if (r_p0 == CH_GT && c == CH_EQ) begin
                bnd  = add_res(bnd, K_SHR_EQ, 1'b0);
                cont = 1'b0;
            end else begin
                bnd = add_held(bnd, r_p0);
            end
        end else if (r_cnt == 2'd1) begin
            n_cnt = 2'd0;
            if (c == r_p0 && (r_p0 == CH_DOT || r_p0 == CH_LT || r_p0 == CH_GT)) begin
                n_cnt = 2'd2;
                cont  = 1'b0;
            end else if (r_p0 == CH_SLASH && c == CH_SLASH) begin
                n_com = 1'b1;
                cont  = 1'b0;
            end else if (pk.hit) begin
                bnd  = add_res(bnd, pk.kind, 1'b0);
                cont = 1'b0;
            end else begin
                bnd = add_res(bnd, short_kind(r_p0).kind, 1'b0);
            end
        end else begin
            n_cnt = 2'd0;
        end

        if (cont) begin
            if (c == CH_SP || c == CH_TAB) begin
                line_inc = 1'b0;
            end else if (c == CH_NL) begin
                line_inc = 1'b1;
            end else if (sk.hit) begin
                n_p0  = c;
                n_cnt = 2'd1;
            end else if (lk.hit) begin
                bnd = add_res(bnd, lk.kind, 1'b0);
            end else begin
                // Unknown character: the kind field reads as code zero.
                bnd     = add_res(bnd, K_LBRACK, 1'b1);
                bnd.off = to_field(r_off);
            end
        end

        n_line = line_inc ? sat_inc(r_line) : r_line;
        n_off  = sat_inc(r_off);

        if (i_in.end_of_source) begin
            if (n_cnt == 2'd2) begin
                bnd = add_held(bnd, n_p0);
            end else if (n_cnt == 2'd1) begin
                bnd = add_res(bnd, short_kind(n_p0).kind, 1'b0);
            end
            n_cnt  = 2'd0;
            n_com  = 1'b0;
            n_line = CNT_ONE;
            n_off  = '0;
        end
    end

    assign o_bundle = bnd;
    assign o_q_push = i_accept && (bnd.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_com  <= 1'b0;
            r_line <= CNT_ONE;
            r_off  <= '0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_com  <= n_com;
            r_line <= n_line;
            r_off  <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p0 <= n_p0;
        end
    end

endmodule

>>> hw/rtl/cpl_queue.sv
// Short queue of result bundles between the front and back ends of the lexer.
// Depends on cpl_pkg.
module cpl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cpl_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output cpl_pkg::t_bundle o_bundle,
    output logic             o_empty
);
    import cpl_pkg::*;

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    assign o_full   = (r_count == QCOUNT_FULL);
    assign o_empty  = (r_count == '0);
    assign o_bundle = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

>>> hw/rtl/cpl_back.sv
// Back end of the lexer: walks the head bundle one result at a time into the
// output register. Depends on cpl_pkg.
module cpl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cpl_pkg::t_bundle i_bundle,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output cpl_pkg::t_out    o_out
);
    import cpl_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_out       r_out;
    logic       load;
    logic       last;
    t_res       cur;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign last    = (r_idx == i_bundle.cnt - 2'd1);
    assign cur     = i_bundle.res[r_idx];
    assign o_q_pop = load && last;
    assign o_empty = !r_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Only an error result carries the byte offset; tokens report zero.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.token_kind  <= cur.kind;
            r_out.is_error    <= cur.err;
            r_out.line_number <= i_bundle.line;
            r_out.byte_offset <= cur.err ? i_bundle.off : '0;
            r_out.last_of_run <= last;
        end
    end

endmodule

>>> hw/rtl/c_punctuator_lexer.sv
// Top level of the C punctuator lexer: front end, bundle queue and back end.
// Depends on cpl_pkg, cpl_front, cpl_queue and cpl_back.
//
//   Channel   Handshake          Payload
//   input     push / full        i_in  (char_byte, end_of_source)
//   result    empty / pop        o_out (token_kind .. last_of_run)
//
// One byte is taken per cycle while the bundle queue has room; each byte yields
// zero to three results, which leave the output register at one per cycle while pop is held.
// A byte's first result passes through the bundle queue and then the output register.
// A stalled result side fills the four-entry queue and then raises full.
// Synchronous active-low reset empties the queue and clears lookahead state.
module c_punctuator_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  cpl_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output cpl_pkg::t_out o_out
);
    import cpl_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_bundle f_bundle;
    t_bundle q_bundle;
    logic    accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    cpl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_q_push (q_push),
        .o_bundle (f_bundle)
    );

    cpl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (f_bundle),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_bundle (q_bundle),
        .o_empty  (q_empty)
    );

    cpl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bundle  (q_bundle),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("Bundle queue popped while empty.");

    a_push_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (f_bundle.cnt != 2'd0))
        else $error("Empty bundle pushed into the queue.");

    a_output_refills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_empty && empty) |=> !empty)
        else $error("Output register idle while a bundle waits.");
`endif

endmodule

>>> sim/c_punctuator_lexer_tb.sv
// Testbench for c_punctuator_lexer: directed and random byte streams, a token predictor
// and a result checker with random idling on both queue interfaces.
// Depends on cpl_pkg and the c_punctuator_lexer RTL.
`timescale 1ns / 1ps

module c_punctuator_lexer_tb;
    import cpl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 300;
    localparam int MAX_GAP      = 13;
    localparam int TAIL_CYCLES  = 8;
    localparam int EOS_PCT      = 3;

    typedef logic [COUNTER_WIDTH-1:0] t_count;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    logic empty;
    logic pop;
    t_in  i_in;
    t_out o_out;

    c_punctuator_lexer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    int         single_kind [0:255];
    bit         grows [0:255];
    int         pair_tab [bit [15:0]];
    int         triple_tab [bit [23:0]];
    bit         triple_head [bit [15:0]];

    logic [7:0] held_char;
    int         held_n;
    bit         skipping;
    t_count     line_now;
    t_count     off_now;
    t_out       byte_results [$];
    t_out       expected_tokens [$];

    int         fails;
    int         bytes_sent;
    int         idle_cycles;
    bit         send_steady;
    bit         pop_steady;

    function automatic string spelling(t_kind k);
        case (k)
            K_LBRACK: return "[";    K_RBRACK: return "]";    K_LPAREN: return "(";
            K_RPAREN: return ")";    K_LBRACE: return "{";    K_RBRACE: return "}";
            K_ELLIPSIS: return "..."; K_DOT: return ".";      K_ARROW: return "->";
            K_DEC: return "--";      K_SUB_EQ: return "-=";   K_SUB: return "-";
            K_INC: return "++";      K_ADD_EQ: return "+=";   K_ADD: return "+";
            K_LAND: return "&&";     K_AND_EQ: return "&=";   K_AND: return "&";
            K_MUL_EQ: return "*=";   K_MUL: return "*";       K_TILDE: return "~";
            K_NE: return "!=";       K_NOT: return "!";       K_DIV_EQ: return "/=";
            K_DIV: return "/";       K_MOD_EQ: return "%=";   K_MOD: return "%";
            K_SHL_EQ: return "<<=";  K_SHL: return "<<";      K_LE: return "<=";
            K_LT: return "<";        K_SHR_EQ: return ">>=";  K_SHR: return ">>";
            K_GE: return ">=";       K_GT: return ">";        K_EQEQ: return "==";
            K_ASSIGN: return "=";    K_XOR_EQ: return "^=";   K_XOR: return "^";
            K_LOR: return "||";      K_OR_EQ: return "|=";    K_OR: return "|";
            K_QUEST: return "?";     K_COLON: return ":";     K_SEMI: return ";";
            default: return ",";
        endcase
    endfunction

    function automatic void build_tables();
        string s;
        for (int i = 0; i < 256; i++) begin
            single_kind[i] = -1;
            grows[i]       = 1'b0;
        end
        for (int k = int'(K_LBRACK); k <= int'(K_COMMA); k++) begin
            s = spelling(t_kind'(k));
            if (s.len() == 1) begin
                single_kind[s[0]] = k;
            end else begin
                grows[s[0]] = 1'b1;
                if (s.len() == 2) begin
                    pair_tab[{s[0], s[1]}] = k;
                end else begin
                    triple_tab[{s[0], s[1], s[2]}] = k;
                    triple_head[{s[0], s[1]}]      = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_count bump(t_count v);
        return v + t_count'(v != CNT_MAX);
    endfunction

    function automatic void add_result(int kind, bit err, t_count off);
        t_out r;
        r.token_kind  = 6'(kind);
        r.is_error    = err;
        r.line_number = FIELD_WIDTH'(line_now);
        r.byte_offset = FIELD_WIDTH'(off);
        r.last_of_run = 1'b0;
        byte_results.push_back(r);
    endfunction

    // A held pair is emitted as its two-character token if one exists, else char by char.
    function automatic void release_held(logic [7:0] p, int n);
        if (n == 2 && pair_tab.exists({p, p})) begin
            add_result(pair_tab[{p, p}], 1'b0, '0);
        end else begin
            for (int i = 0; i < n; i++) add_result(single_kind[p], 1'b0, '0);
        end
    endfunction

    function automatic void lex_char(logic [7:0] c, t_count off);
        logic [7:0] p;
        if (skipping) begin
            if (c == CH_NL) begin
                skipping = 1'b0;
                line_now = bump(line_now);
            end
            return;
        end
        p = held_char;
        if (held_n == 2) begin
            held_n = 0;
            if (triple_tab.exists({p, p, c})) begin
                add_result(triple_tab[{p, p, c}], 1'b0, '0);
                return;
            end
            release_held(p, 2);
        end else if (held_n == 1) begin
            held_n = 0;
            if (c == p && triple_head.exists({p, p})) begin
                held_n = 2;
                return;
            end
            if (p == CH_SLASH && c == CH_SLASH) begin
                skipping = 1'b1;
                return;
            end
            if (pair_tab.exists({p, c})) begin
                add_result(pair_tab[{p, c}], 1'b0, '0);
                return;
            end
            release_held(p, 1);
        end
        if (c == CH_SP || c == CH_TAB) return;
        if (c == CH_NL) begin
            line_now = bump(line_now);
            return;
        end
        if (grows[c]) begin
            held_char = c;
            held_n    = 1;
        end else if (single_kind[c] >= 0) begin
            add_result(single_kind[c], 1'b0, '0);
        end else begin
            add_result(int'(K_LBRACK), 1'b1, off);
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] c, bit eos);
        t_count off;
        off     = off_now;
        off_now = bump(off_now);
        byte_results.delete();
        lex_char(c, off);
        if (eos) begin
            release_held(held_char, held_n);
            held_n   = 0;
            skipping = 1'b0;
            line_now = CNT_ONE;
            off_now  = '0;
        end
        if (byte_results.size() > 0) byte_results[byte_results.size()-1].last_of_run = 1'b1;
        foreach (byte_results[i]) expected_tokens.push_back(byte_results[i]);
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(MAX_GAP, 0);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) predict_tokens(i_in.char_byte, i_in.end_of_source);
    end

    always @(posedge i_clk) begin : check_result
        t_out want;
        if (i_rst_n && pop && !empty) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result: token_kind %0d is_error %0d",
                       o_out.token_kind, o_out.is_error);
                fails++;
            end else begin
                want = expected_tokens.pop_front();
                if (o_out.token_kind !== want.token_kind) begin
                    $error("token_kind: expected %0d, actual %0d",
                           want.token_kind, o_out.token_kind);
                    fails++;
                end
                if (o_out.is_error !== want.is_error) begin
                    $error("is_error: expected %0d, actual %0d", want.is_error, o_out.is_error);
                    fails++;
                end
                if (o_out.line_number !== want.line_number) begin
                    $error("line_number: expected %0d, actual %0d",
                           want.line_number, o_out.line_number);
                    fails++;
                end
                if (o_out.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, actual %0d",
                           want.byte_offset, o_out.byte_offset);
                    fails++;
                end
                if (o_out.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, o_out.last_of_run);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : drain_results
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(pop_steady);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (!(pop && !empty));
        end
    end

    task automatic send_byte(logic [7:0] c, bit eos);
        int gap;
        gap = draw_gap(send_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= '{char_byte: c, end_of_source: eos};
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit eos_at_end, int eos_pct);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], (eos_at_end && i == s.len() - 1) ||
                            ($urandom_range(99, 0) < eos_pct));
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    task automatic test_three_char_tokens();
        send_steady = 1'b1;
        pop_steady  = 1'b1;
        send_text("...<<=>>=", 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_held_pair_release();
        send_steady = 1'b0;
        pop_steady  = 1'b1;
        send_text("..;", 1'b0, 0);
        send_text("<<", 1'b1, 0);
        wait_idle();
    endtask

    task automatic test_lookahead_overtaken();
        send_steady = 1'b1;
        pop_steady  = 1'b0;
        send_text("!~", 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_line_comment();
        send_steady = 1'b0;
        pop_steady  = 1'b0;
        send_text("//=\n", 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_blanks_and_bad_bytes();
        send_steady = 1'b1;
        pop_steady  = 1'b0;
        send_text(" \t\n", 1'b0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    // Mostly well-formed punctuator streams, with blanks, comments, held pairs and noise.
    task automatic test_random_source();
        int start;
        int next_roll;
        int sel;
        start     = bytes_sent;
        next_roll = start;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent >= next_roll) begin
                send_steady = ($urandom_range(3, 0) == 0);
                pop_steady  = ($urandom_range(3, 0) == 0);
                next_roll   = bytes_sent + 40;
            end
            sel = $urandom_range(99, 0);
            if (sel < 58) begin
                send_text(spelling(t_kind'($urandom_range(int'(K_COMMA), int'(K_LBRACK)))),
                          1'b0, EOS_PCT);
            end else if (sel < 70) begin
                case ($urandom_range(2, 0))
                    0: send_text(" ", 1'b0, EOS_PCT);
                    1: send_text("\t", 1'b0, EOS_PCT);
                    default: send_text("\n", 1'b0, EOS_PCT);
                endcase
            end else if (sel < 78) begin
                send_text("//", 1'b0, EOS_PCT);
                repeat ($urandom_range(5, 0)) begin
                    send_byte(8'($urandom_range(8'h7E, 8'h20)), $urandom_range(99, 0) < EOS_PCT);
                end
                send_byte(CH_NL, $urandom_range(99, 0) < EOS_PCT);
            end else if (sel < 88) begin
                case ($urandom_range(2, 0))
                    0: send_text("..", 1'b0, EOS_PCT);
                    1: send_text("<<", 1'b0, EOS_PCT);
                    default: send_text(">>", 1'b0, EOS_PCT);
                endcase
            end else if (sel < 96) begin
                send_byte(8'($urandom_range(255, 0)), 1'b0);
            end else begin
                send_byte(8'($urandom_range(255, 0)), 1'b1);
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_in        <= '0;
        idle_cycles <= 0;
        fails       = 0;
        bytes_sent  = 0;
        send_steady = 1'b0;
        pop_steady  = 1'b0;
        held_char   = '0;
        held_n      = 0;
        skipping    = 1'b0;
        line_now    = CNT_ONE;
        off_now     = '0;
        build_tables();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_three_char_tokens();
        test_held_pair_release();
        test_lookahead_overtaken();
        test_line_comment();
        test_blanks_and_bad_bytes();
        test_random_source();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_tokens.size() != 0) begin
            $error("%0d expected results never arrived", expected_tokens.size());
            fails++;
        end
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
